FILE: rtl/ijps_pkg.sv
package ijps_pkg;

  localparam int MaxJobs = 64;
  localparam int AddrW = $clog2(MaxJobs);
  localparam int CntW = $clog2(MaxJobs + 1);

  localparam logic [7:0] RegIntervalStart = 8'd0;
  localparam logic [7:0] RegIntervalEnd = 8'd1;

  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] proc_time;
    logic [15:0] job_weight;
    logic [15:0] due_time;
    logic        last_job;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_job_id;
    logic [15:0] out_proc_time;
    logic [15:0] out_weight;
    logic [15:0] out_due_time;
    logic        last_out;
    logic [6:0]  begin_index;
  } out_req_t;

  typedef struct packed {
    logic [15:0] job_id;
    logic [15:0] proc_time;
    logic [15:0] job_weight;
    logic [15:0] due_time;
  } job_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic emit_last;
  } ctrl_sts_t;

endpackage

FILE: rtl/interval_job_priority_sorter_unit.sv
// channel  | ports                          | moves
// ---------+--------------------------------+------------------------------
// input    | start, busy, in_job            | one job request per accept
// result   | out_valid, out_res             | one sorted job, one-cycle strobe
// config   | cfg_we, cfg_idx, cfg_data      | interval start / end write
//
// jobs load one per cycle while idle; the final job starts the sort
// sort is a selection scan over the job memory: each entry read steps
// through memory read, cross-multiply and compare, and each full scan
// of the stored jobs ends in one emitted result
// reset: synchronous active low, clears count and phase; the store holds junk
// the receiver cannot stall; results are strobed for one cycle each
module interval_job_priority_sorter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ijps_pkg::in_req_t  in_job,
  output logic               out_valid,
  output ijps_pkg::out_req_t out_res,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_idx,
  input  logic [15:0]        cfg_data
);

  ijps_pkg::ctrl_cmd_t cmd;
  ijps_pkg::ctrl_sts_t sts;
  logic accept;

  // request taken only while loading
  assign accept = start && !busy;

  ijps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .accept(accept), .last_job(in_job.last_job),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  ijps_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .in_job(in_job), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_res(out_res)
  );

endmodule

FILE: rtl/ijps_ctrl.sv
module ijps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                last_job,
  input  ijps_pkg::ctrl_sts_t sts,
  output ijps_pkg::ctrl_cmd_t cmd,
  output logic                busy
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && last_job) state_nxt = S_READ;
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CMP;
      S_CMP:  state_nxt = sts.scan_last ? S_EMIT : S_READ;
      S_EMIT: state_nxt = sts.emit_last ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign cmd.load = accept;
  assign cmd.cmp = (state_r == S_CMP);
  assign cmd.emit = (state_r == S_EMIT);

endmodule

FILE: rtl/ijps_datapath.sv
module ijps_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  ijps_pkg::in_req_t   in_job,
  input  ijps_pkg::ctrl_cmd_t cmd,
  output ijps_pkg::ctrl_sts_t sts,
  output logic                out_valid,
  output ijps_pkg::out_req_t  out_res
);

  localparam int AW = ijps_pkg::AddrW;
  localparam int CW = ijps_pkg::CntW;

  ijps_pkg::job_t mem [ijps_pkg::MaxJobs];
  ijps_pkg::job_t rd_r, best_r, best_nxt;
  logic [15:0] start_r, end_r;
  logic [CW-1:0] cnt_r, out_cnt_r;
  logic [AW-1:0] scan_r, best_idx_r;
  logic best_vld_r;
  logic [ijps_pkg::MaxJobs-1:0] done_r;
  logic [31:0] lhs_r, rhs_r;
  logic [6:0] run_r;
  logic in_run_r;

  logic signed [17:0] len;
  logic [15:0] cn, cd, bn, bd;
  logic cl, bl, better, ge, take;
  logic [6:0] run_nxt;

  // effective ratio: zero when due after interval start or proc is zero
  always_comb begin
    len = 18'(signed'({1'b0, end_r})) - 18'(signed'({1'b0, start_r}));
    if (rd_r.due_time <= start_r && rd_r.proc_time != 16'd0) begin
      cn = rd_r.job_weight; cd = rd_r.proc_time;
    end else begin
      cn = 16'd0; cd = 16'd1;
    end
    if (best_r.due_time <= start_r && best_r.proc_time != 16'd0) begin
      bn = best_r.job_weight; bd = best_r.proc_time;
    end else begin
      bn = 16'd0; bd = 16'd1;
    end
    cl = signed'({2'b00, rd_r.proc_time}) > len;
    bl = signed'({2'b00, best_r.proc_time}) > len;
    if (cl != bl) better = cl;
    else if (lhs_r != rhs_r) better = lhs_r > rhs_r;
    else if (rd_r.proc_time != best_r.proc_time) better = rd_r.proc_time > best_r.proc_time;
    else better = rd_r.job_id < best_r.job_id;
    take = !done_r[scan_r] && (!best_vld_r || better);
    best_nxt = best_r;
    ge = signed'({2'b00, best_r.proc_time}) >= len;
    run_nxt = (in_run_r && ge) ? run_r + 7'd1 : run_r;
  end

  assign sts.scan_last = ({1'b0, scan_r} == cnt_r - CW'(1));
  assign sts.emit_last = (out_cnt_r == cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    rd_r <= mem[scan_r];
    lhs_r <= cn * bd;
    rhs_r <= bn * cd;
    if (cmd.load && cnt_r < CW'(ijps_pkg::MaxJobs)) begin
      mem[cnt_r[AW-1:0]] <= '{in_job.job_id, in_job.proc_time,
                              in_job.job_weight, in_job.due_time};
    end
    if (cmd.cmp && take) best_r <= rd_r;
    else best_r <= best_nxt;
    if (cmd.cmp && take) best_idx_r <= scan_r;
    if (cmd.emit) begin
      out_res.out_job_id <= best_r.job_id;
      out_res.out_proc_time <= best_r.proc_time;
      out_res.out_weight <= best_r.job_weight;
      out_res.out_due_time <= best_r.due_time;
      out_res.last_out <= sts.emit_last;
      out_res.begin_index <= sts.emit_last ? run_nxt : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; end_r <= '0; cnt_r <= '0; out_cnt_r <= '0;
      scan_r <= '0; best_vld_r <= 1'b0; done_r <= '0;
      run_r <= '0; in_run_r <= 1'b1; out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
      if (cfg_we && cfg_idx == ijps_pkg::RegIntervalStart) start_r <= cfg_data;
      if (cfg_we && cfg_idx == ijps_pkg::RegIntervalEnd) end_r <= cfg_data;
      if (cmd.load && cnt_r < CW'(ijps_pkg::MaxJobs)) cnt_r <= cnt_r + CW'(1);
      if (cmd.cmp) begin
        scan_r <= scan_r + AW'(1);
        if (take) best_vld_r <= 1'b1;
      end
      if (cmd.emit) begin
        scan_r <= '0;
        best_vld_r <= 1'b0;
        done_r[best_idx_r] <= 1'b1;
        run_r <= run_nxt;
        in_run_r <= in_run_r && ge;
        out_cnt_r <= out_cnt_r + CW'(1);
        if (sts.emit_last) begin
          // run complete, back to loading
          cnt_r <= '0; out_cnt_r <= '0; done_r <= '0;
          run_r <= '0; in_run_r <= 1'b1;
        end
      end
    end
  end

  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> best_vld_r) else $error("emit without a selected job");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ijps_pkg::MaxJobs)) else $error("job count overflow");
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (cnt_r == '0 && done_r == '0))
    else $error("run end did not clear state");

endmodule
